// ===== design/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the set-associative PLRU cache.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_PAD_W   = 3;

   localparam logic       ACT_WRITE = 1'b1;
   localparam logic [3:0] MIN_SIZE  = 4'd1;
   localparam logic [3:0] MAX_SIZE  = 4'd8;

   // A request after classification: n1 bytes in the first line, n2 in the next.
   typedef struct packed {
      logic        is_write;
      logic [15:0] address;
      logic [3:0]  n1;
      logic [3:0]  n2;
      logic [63:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  writebacks;
      logic        second_hit;
      logic        crossed_line;
      logic        first_hit;
      logic [63:0] read_data;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== design/scp_ram.sv =====
// ----------------------------------------------------------------------------
// scp_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/scp_front.sv =====
// ----------------------------------------------------------------------------
// scp_front
// Accepts requests, clamps the size and splits it at the line boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_front import scp_pkg::*; #(
   parameter int LINE_LOG2 = 5
) (
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   q_full,
   input  wire logic                   hold,
   output logic                        q_push,
   output req_item_type                q_item
);

   localparam int LINE_SIZE = 1 << LINE_LOG2;

   logic [3:0]           size_raw;
   logic [3:0]           size_n;
   logic [LINE_LOG2-1:0] off;
   logic [LINE_LOG2:0]   room;
   logic [3:0]           n1;

   always_comb begin
      size_raw = req_tdata[19:16];
      if (size_raw == 4'd0) begin
         size_n = MIN_SIZE;
      end else if (size_raw > MAX_SIZE) begin
         size_n = MAX_SIZE;
      end else begin
         size_n = size_raw;
      end
      off  = req_tdata[LINE_LOG2-1:0];
      room = (LINE_LOG2+1)'(LINE_SIZE) - (LINE_LOG2+1)'(off);
      if (room < (LINE_LOG2+1)'(size_n)) begin
         n1 = room[3:0];
      end else begin
         n1 = size_n;
      end
      q_item.is_write   = (req_tuser == ACT_WRITE);
      q_item.address    = req_tdata[15:0];
      q_item.n1         = n1;
      q_item.n2         = size_n - n1;
      q_item.write_data = req_tdata[83:20];
   end

   assign req_tready = !q_full && !hold;
   assign q_push     = req_tvalid && req_tready;

endmodule

`default_nettype wire

// ===== design/scp_queue.sv =====
// ----------------------------------------------------------------------------
// scp_queue
// Two-entry queue between the request front end and the cache engine.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_queue import scp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  req_item_type push_item,
   input  wire logic   pop,
   output req_item_type pop_item,
   output logic        full,
   output logic        empty
);

   req_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);

endmodule

`default_nettype wire

// ===== design/scp_back.sv =====
// ----------------------------------------------------------------------------
// scp_back
// Cache engine: lookup, eviction, fill, byte access and PLRU update.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_back import scp_pkg::*; #(
   parameter int WAYS_LOG2 = 2,
   parameter int SET_BITS  = 6,
   parameter int LINE_LOG2 = 5,
   parameter int ADDR_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   write_back,
   input  wire logic   q_empty,
   input  req_item_type q_item,
   output logic        q_pop,
   output logic        clear_busy,
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   output rsp_item_type rsp_item
);

   localparam int NWAYS      = 1 << WAYS_LOG2;
   localparam int NSETS      = 1 << SET_BITS;
   localparam int LINE_SIZE  = 1 << LINE_LOG2;
   localparam int NLINES     = NSETS * NWAYS;
   localparam int TAG_BITS   = ADDR_BITS - SET_BITS - LINE_LOG2;
   localparam int LADDR_BITS = ADDR_BITS - LINE_LOG2;
   localparam int IDX_BITS   = SET_BITS + WAYS_LOG2;
   localparam int LB_ABITS   = IDX_BITS + LINE_LOG2;
   localparam int PL_BITS    = NWAYS - 1;
   localparam int ROW_BITS   = NWAYS * TAG_BITS;
   // Per-set metadata row: PLRU tree on top, then dirty bits, then valid bits.
   localparam int META_W     = PL_BITS + 2 * NWAYS;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_TAGRD  = 8'b0000_0100,
      S_TAGCMP = 8'b0000_1000,
      S_COPY   = 8'b0001_0000,
      S_ACCESS = 8'b0010_0000,
      S_TOUCH  = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      CP_EVICT,
      CP_FILL,
      CP_THROUGH
   } copy_kind_type;

   state_type             state_ff, state_in;
   copy_kind_type         kind_ff, kind_in;
   req_item_type          cur_ff, cur_in;
   logic                  second_ff, second_in;
   logic [LADDR_BITS-1:0] laddr_ff, laddr_in;
   logic [LINE_LOG2-1:0]  off_ff, off_in;
   logic [3:0]            nbytes_ff, nbytes_in;
   logic [2:0]            base_ff, base_in;
   logic [WAYS_LOG2-1:0]  way_ff, way_in;
   logic                  h1_ff, h1_in, h2_ff, h2_in;
   logic [1:0]            wbs_ff, wbs_in;
   logic [63:0]           buf_ff, buf_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [META_W-1:0]     meta_ff, meta_in;
   logic [LINE_LOG2:0]    cnt_ff, cnt_in;
   logic [LADDR_BITS-1:0] bk_line_ff, bk_line_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;

   logic                  meta_we;
   logic [SET_BITS-1:0]   meta_waddr;
   logic [META_W-1:0]     meta_wdata, meta_rdata;
   logic [NWAYS-1:0]      rd_valid, rd_dirty;
   logic [PL_BITS-1:0]    rd_plru, wk_plru;

   logic                  tag_we;
   logic [ROW_BITS-1:0]   tag_wdata, tag_rdata;
   logic                  lb_we, bk_we;
   logic [LB_ABITS-1:0]   lb_waddr, lb_raddr;
   logic [ADDR_BITS-1:0]  bk_waddr, bk_raddr;
   logic [7:0]            lb_wdata, lb_rdata, bk_wdata, bk_rdata;

   logic [SET_BITS-1:0]   set_w;
   logic [TAG_BITS-1:0]   tag_w;
   logic [IDX_BITS-1:0]   idx_w;
   logic [LINE_LOG2-1:0]  cnt_lo, cnt_m1, acc_off;
   logic [2:0]            wr_pos, cap_pos;
   logic                  copy_last, acc_last;
   logic                  hit;
   logic [WAYS_LOG2-1:0]  hit_way, victim;
   logic [TAG_BITS-1:0]   victim_tag;
   logic [ADDR_BITS-1:0]  addr_a;
   logic [PL_BITS-1:0]    bits_v;
   int                    node;

   assign set_w     = laddr_ff[SET_BITS-1:0];
   assign tag_w     = laddr_ff[LADDR_BITS-1:SET_BITS];
   assign idx_w     = {set_w, way_ff};
   assign cnt_lo    = cnt_ff[LINE_LOG2-1:0];
   assign cnt_m1    = cnt_lo - LINE_LOG2'(1);
   assign acc_off   = off_ff + cnt_lo;
   assign wr_pos    = base_ff + cnt_ff[2:0];
   assign cap_pos   = base_ff + cnt_m1[2:0];
   assign copy_last = (cnt_ff == (LINE_LOG2+1)'(LINE_SIZE));
   assign acc_last  = (cnt_ff == (LINE_LOG2+1)'(nbytes_ff));
   assign addr_a    = ADDR_BITS'(q_item.address);

   // The metadata row read for the set is valid in the compare state; the
   // working copy in meta_ff carries it through the rest of the line access.
   assign rd_valid = meta_rdata[NWAYS-1:0];
   assign rd_dirty = meta_rdata[2*NWAYS-1:NWAYS];
   assign rd_plru  = meta_rdata[META_W-1:2*NWAYS];
   assign wk_plru  = meta_ff[META_W-1:2*NWAYS];

   // Tag compare across the ways of the set; the lowest matching way wins.
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (rd_valid[w] && tag_rdata[w*TAG_BITS +: TAG_BITS] == tag_w) begin
            hit     = 1'b1;
            hit_way = WAYS_LOG2'(w);
         end
      end
   end

   // Victim walk from the root and path update for the accessed way.
   always_comb begin
      node = 1;
      for (int l = 0; l < WAYS_LOG2; l++) begin
         node = 2 * node + int'(rd_plru[node-1]);
      end
      victim     = WAYS_LOG2'(node - NWAYS);
      victim_tag = tag_rdata[victim*TAG_BITS +: TAG_BITS];
      bits_v     = wk_plru;
      node       = 1;
      for (int l = 0; l < WAYS_LOG2; l++) begin
         bits_v[node-1] = !way_ff[WAYS_LOG2-1-l];
         node = 2 * node + int'(way_ff[WAYS_LOG2-1-l]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cur_in       = cur_ff;
      second_in    = second_ff;
      laddr_in     = laddr_ff;
      off_in       = off_ff;
      nbytes_in    = nbytes_ff;
      base_in      = base_ff;
      way_in       = way_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      wbs_in       = wbs_ff;
      buf_in       = buf_ff;
      row_in       = row_ff;
      meta_in      = meta_ff;
      cnt_in       = cnt_ff;
      bk_line_in   = bk_line_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      meta_we      = 1'b0;
      meta_waddr   = set_w;
      meta_wdata   = {bits_v, meta_ff[2*NWAYS-1:0]};
      tag_we       = 1'b0;
      tag_wdata    = row_ff;
      tag_wdata[way_ff*TAG_BITS +: TAG_BITS] = tag_w;
      lb_we        = 1'b0;
      lb_waddr     = {idx_w, cnt_m1};
      lb_wdata     = bk_rdata;
      lb_raddr     = {idx_w, cnt_lo};
      bk_we        = 1'b0;
      bk_waddr     = {bk_line_ff, cnt_m1};
      bk_wdata     = lb_rdata;
      bk_raddr     = {bk_line_ff, cnt_lo};

      unique case (state_ff)
         S_CLEAR: begin
            bk_we      = 1'b1;
            bk_waddr   = clr_ff;
            bk_wdata   = 8'h00;
            meta_we    = 1'b1;
            meta_waddr = clr_ff[SET_BITS-1:0];
            meta_wdata = '0;
            clr_in     = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               cur_in    = q_item;
               laddr_in  = addr_a[ADDR_BITS-1:LINE_LOG2];
               off_in    = addr_a[LINE_LOG2-1:0];
               nbytes_in = q_item.n1;
               base_in   = 3'd0;
               second_in = 1'b0;
               h1_in     = 1'b0;
               h2_in     = 1'b0;
               wbs_in    = 2'd0;
               buf_in    = '0;
               state_in  = S_TAGRD;
            end
         end
         S_TAGRD: begin
            state_in = S_TAGCMP;
         end
         S_TAGCMP: begin
            row_in  = tag_rdata;
            meta_in = meta_rdata;
            cnt_in  = '0;
            if (second_ff) begin
               h2_in = hit;
            end else begin
               h1_in = hit;
            end
            if (hit) begin
               way_in   = hit_way;
               state_in = S_ACCESS;
            end else begin
               way_in   = victim;
               state_in = S_COPY;
               if (write_back && rd_valid[victim] && rd_dirty[victim]) begin
                  kind_in    = CP_EVICT;
                  bk_line_in = {victim_tag, set_w};
                  wbs_in     = wbs_ff + 2'd1;
               end else begin
                  kind_in    = CP_FILL;
                  bk_line_in = laddr_ff;
               end
            end
         end
         S_COPY: begin
            cnt_in = cnt_ff + (LINE_LOG2+1)'(1);
            if (kind_ff == CP_FILL) begin
               lb_we = (cnt_ff != '0);
            end else begin
               bk_we = (cnt_ff != '0);
            end
            if (copy_last) begin
               cnt_in = '0;
               case (kind_ff)
                  CP_EVICT: begin
                     kind_in    = CP_FILL;
                     bk_line_in = laddr_ff;
                  end
                  CP_FILL: begin
                     // A freshly filled line is valid and clean.
                     tag_we                      = 1'b1;
                     meta_in[way_ff]             = 1'b1;
                     meta_in[NWAYS+int'(way_ff)] = 1'b0;
                     state_in                    = S_ACCESS;
                  end
                  default: begin
                     state_in = S_TOUCH;
                  end
               endcase
            end
         end
         S_ACCESS: begin
            lb_raddr = {idx_w, acc_off};
            lb_waddr = {idx_w, acc_off};
            lb_wdata = cur_ff.write_data[{wr_pos, 3'b000} +: 8];
            cnt_in   = cnt_ff + (LINE_LOG2+1)'(1);
            if (cur_ff.is_write) begin
               lb_we = !acc_last;
            end else if (cnt_ff != '0) begin
               buf_in[{cap_pos, 3'b000} +: 8] = lb_rdata;
            end
            if (acc_last) begin
               cnt_in = '0;
               if (cur_ff.is_write) begin
                  meta_in[NWAYS+int'(way_ff)] = write_back;
                  if (write_back) begin
                     state_in = S_TOUCH;
                  end else begin
                     kind_in    = CP_THROUGH;
                     bk_line_in = laddr_ff;
                     state_in   = S_COPY;
                  end
               end else begin
                  state_in = S_TOUCH;
               end
            end
         end
         S_TOUCH: begin
            // The updated metadata row goes back to the set in one write.
            meta_we = 1'b1;
            if (!second_ff && cur_ff.n2 != 4'd0) begin
               second_in = 1'b1;
               laddr_in  = laddr_ff + LADDR_BITS'(1);
               off_in    = '0;
               nbytes_in = cur_ff.n2;
               base_in   = cur_ff.n1[2:0];
               state_in  = S_TAGRD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.read_data     = buf_ff;
               rsp_in.first_hit     = h1_ff;
               rsp_in.crossed_line  = (cur_ff.n2 != 4'd0);
               rsp_in.second_hit    = h2_ff;
               rsp_in.writebacks    = wbs_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      cur_ff     <= cur_in;
      second_ff  <= second_in;
      laddr_ff   <= laddr_in;
      off_ff     <= off_in;
      nbytes_ff  <= nbytes_in;
      base_ff    <= base_in;
      way_ff     <= way_in;
      h1_ff      <= h1_in;
      h2_ff      <= h2_in;
      wbs_ff     <= wbs_in;
      buf_ff     <= buf_in;
      row_ff     <= row_in;
      meta_ff    <= meta_in;
      cnt_ff     <= cnt_in;
      bk_line_ff <= bk_line_in;
      rsp_ff     <= rsp_in;
   end

   scp_ram #(.WIDTH(META_W), .DEPTH(NSETS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (set_w),
      .rd_data (meta_rdata)
   );

   scp_ram #(.WIDTH(ROW_BITS), .DEPTH(NSETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (set_w),
      .wr_data (tag_wdata),
      .rd_addr (set_w),
      .rd_data (tag_rdata)
   );

   scp_ram #(.WIDTH(8), .DEPTH(NLINES * LINE_SIZE)) u_line_ram (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (lb_waddr),
      .wr_data (lb_wdata),
      .rd_addr (lb_raddr),
      .rd_data (lb_rdata)
   );

   scp_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_backing_ram (
      .clock   (clock),
      .wr_en   (bk_we),
      .wr_addr (bk_waddr),
      .wr_data (bk_wdata),
      .rd_addr (bk_raddr),
      .rd_data (bk_rdata)
   );

   assign clear_busy = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== design/set_assoc_cache_tree_plru.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tree_plru
// Set-associative cache with tree pseudo-LRU replacement over a local store.
// ----------------------------------------------------------------------------
// Each request reads or writes 1 to 8 little-endian bytes; an access that runs
// past the end of a line is done as two line accesses, and one response comes
// back per request. After reset the block sweeps the backing store to zero,
// one byte per cycle, and holds off requests until the sweep is done; the
// valid, dirty and PLRU bits of every set are zeroed in the same sweep.
// Requests are then taken one at a time by the engine, while a two-entry
// queue keeps accepting. A line access that hits reads the tag and metadata,
// compares them and moves the bytes; a miss first fills the line from the
// backing store, preceded by a writeback when the victim is dirty in
// write-back mode, and a write-through write copies the line out after the
// access. Every transfer moves one byte per cycle through the line and
// backing memories.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tree_plru import scp_pkg::*; #(
   parameter int WAYS_LOG2 = 2,
   parameter int SET_BITS  = 6,
   parameter int LINE_LOG2 = 5,
   parameter int ADDR_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // address[15:0], size_bytes[19:16], write_data[83:20], zero above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // action: 0 read, 1 write
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_data[63:0], first_hit[64], crossed_line[65], second_hit[66],
   // writebacks[68:67], zero above
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_wr_data
);

   logic         write_back_ff, write_back_in;
   logic         q_full, q_empty, q_push, q_pop, clear_busy;
   req_item_type push_item, pop_item;
   rsp_item_type rsp_item;

   // Write-back mode register; it resets to write-back.
   assign write_back_in = csr_wr_en ? csr_wr_data : write_back_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_back_ff <= 1'b1;
      end else begin
         write_back_ff <= write_back_in;
      end
   end

   // The front end clamps the size and works out the split at the line edge.
   scp_front #(.LINE_LOG2(LINE_LOG2)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .hold       (clear_busy),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   scp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The engine owns the tag, metadata, line and backing memories and the
   // response register.
   scp_back #(
      .WAYS_LOG2 (WAYS_LOG2),
      .SET_BITS  (SET_BITS),
      .LINE_LOG2 (LINE_LOG2),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .write_back (write_back_ff),
      .q_empty    (q_empty),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_item};

endmodule

`default_nettype wire

// ===== test/set_assoc_cache_tree_plru_test.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tree_plru_test
// Self-checking testbench for the tree-PLRU set-associative cache.
// ----------------------------------------------------------------------------
// A behavioral copy of the cache (tags, valid and dirty bits, PLRU trees, line
// bytes and the backing store) predicts one response per accepted request. A
// monitor compares each response, field by field, with the oldest prediction.
// The run covers directed corner cases, both write policies, back-pressure
// that fills the request queue, and random traffic. Most random addresses are
// packed into a few sets, so hits, evictions and dirty writebacks are common.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tree_plru_test
   import scp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic                   csr_wr_data;

   set_assoc_cache_tree_plru u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   localparam int LINE_BYTES = 32;
   localparam int NUM_SETS   = 64;
   localparam int NUM_WAYS   = 4;
   localparam int SETTLE     = 200;

   // Shadow copy of the cache and its backing store.
   logic [4:0]   shadow_tag   [NUM_SETS*NUM_WAYS];
   bit           shadow_valid [NUM_SETS*NUM_WAYS];
   bit           shadow_dirty [NUM_SETS*NUM_WAYS];
   logic [2:0]   shadow_plru  [NUM_SETS];
   logic [7:0]   shadow_line  [NUM_SETS*NUM_WAYS*LINE_BYTES];
   logic [7:0]   shadow_mem   [65536];
   bit           shadow_write_back;
   logic [7:0]   xfer_bytes   [8];

   rsp_item_type pending_rsp[$];
   int           error_count;
   int           request_count;
   int           response_count;
   int           hit_count;
   int           cross_count;
   int           writeback_count;
   int           idle_pct;
   int           stall_pct;
   int           hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch %0d: %s got %h expected %h", response_count, what, got, want);
   endtask

   // One line access on the shadow cache; returns 1 on a hit.
   function automatic bit shadow_line_access(input int laddr, input int off, input int n,
                                             input bit is_write, input int base,
                                             inout int wbs);
      int set_idx;
      int tag;
      int way;
      int idx;
      int node;
      int old_base;
      int new_base;
      int d;
      bit hit;
      set_idx = laddr & (NUM_SETS - 1);
      tag     = laddr >> 6;
      hit     = 1'b0;
      way     = 0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!hit && shadow_valid[set_idx*NUM_WAYS+w] &&
             shadow_tag[set_idx*NUM_WAYS+w] == tag) begin
            hit = 1'b1;
            way = w;
         end
      end
      new_base = (laddr << 5) & 16'hFFFF;
      if (!hit) begin
         // Follow the tree from the root; a zero bit points to the lower half.
         node = 1;
         for (int lvl = 0; lvl < 2; lvl++) node = 2 * node + shadow_plru[set_idx][node-1];
         way = node - NUM_WAYS;
         idx = set_idx * NUM_WAYS + way;
         if (shadow_write_back && shadow_valid[idx] && shadow_dirty[idx]) begin
            old_base = (((shadow_tag[idx] << 6) | set_idx) << 5) & 16'hFFFF;
            for (int i = 0; i < LINE_BYTES; i++)
               shadow_mem[old_base+i] = shadow_line[idx*LINE_BYTES+i];
            wbs++;
         end
         for (int i = 0; i < LINE_BYTES; i++)
            shadow_line[idx*LINE_BYTES+i] = shadow_mem[new_base+i];
         shadow_valid[idx] = 1'b1;
         shadow_tag[idx]   = tag[4:0];
         shadow_dirty[idx] = 1'b0;
      end
      idx = set_idx * NUM_WAYS + way;
      for (int i = 0; i < n; i++) begin
         if (is_write) shadow_line[idx*LINE_BYTES+((off+i) & 31)] = xfer_bytes[base+i];
         else xfer_bytes[base+i] = shadow_line[idx*LINE_BYTES+((off+i) & 31)];
      end
      if (is_write) begin
         if (shadow_write_back) begin
            shadow_dirty[idx] = 1'b1;
         end else begin
            for (int i = 0; i < LINE_BYTES; i++)
               shadow_mem[new_base+i] = shadow_line[idx*LINE_BYTES+i];
            shadow_dirty[idx] = 1'b0;
         end
      end
      // Point every node on the path away from the way just used.
      node = 1;
      for (int lvl = 0; lvl < 2; lvl++) begin
         d = (way >> (1 - lvl)) & 1;
         shadow_plru[set_idx][node-1] = (d == 0);
         node = 2 * node + d;
      end
      return hit;
   endfunction

   function automatic rsp_item_type predict_response(input bit is_write,
                                                     input logic [15:0] address,
                                                     input logic [3:0] size_field,
                                                     input logic [63:0] wdata);
      rsp_item_type r;
      int size;
      int off;
      int n1;
      int n2;
      int wbs;
      int laddr;
      size = (size_field == 0) ? 1 : (size_field > 8) ? 8 : size_field;
      for (int i = 0; i < 8; i++) xfer_bytes[i] = is_write ? wdata[8*i +: 8] : 8'h00;
      laddr = address >> 5;
      off   = address & 31;
      n1    = (LINE_BYTES - off < size) ? LINE_BYTES - off : size;
      n2    = size - n1;
      wbs   = 0;
      r     = '0;
      r.first_hit = shadow_line_access(laddr, off, n1, is_write, 0, wbs);
      if (n2 > 0) begin
         r.crossed_line = 1'b1;
         // The line after the top of the address space is line zero.
         r.second_hit = shadow_line_access((laddr + 1) & 11'h7FF, 0, n2, is_write, n1, wbs);
      end
      if (!is_write)
         for (int i = 0; i < size; i++) r.read_data[8*i +: 8] = xfer_bytes[i];
      r.writebacks = wbs[1:0];
      return r;
   endfunction

   // Offers one request after a random idle gap, waits for the handshake and
   // records the predicted response. Valid stays high for the next request.
   task automatic send_request(input bit is_write, input logic [15:0] address,
                               input logic [3:0] size_field, input logic [63:0] wdata);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_write;
      req_tdata  <= {4'b0, wdata, size_field, address};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_response(is_write, address, size_field, wdata));
      request_count++;
   endtask

   // Drops valid and waits until every predicted response has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Policy changes happen only on an idle block, with some margin for the
   // engine to finish up after its last response.
   task automatic set_write_back(input bit mode);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_write_back = mode;
   endtask

   // Most addresses land in four sets with twelve tags, forcing evictions.
   function automatic logic [15:0] pick_address;
      logic [15:0] a;
      if ($urandom_range(9) < 7) begin
         a[15:11] = 5'($urandom_range(5));
         a[10:5]  = 6'($urandom_range(3));
         a[4:0]   = 5'($urandom_range(31));
         if ($urandom_range(3) == 0) a[15:11] = ~a[15:11];
      end else begin
         a = 16'($urandom);
      end
      return a;
   endfunction

   task automatic random_request;
      logic [3:0] size_field;
      size_field = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8, 1));
      send_request(1'($urandom_range(1)), pick_address(), size_field, {$urandom, $urandom});
   endtask

   task automatic test_directed;
      idle_pct  = 0;
      stall_pct = 0;
      // Reads of a cleared store, then writes and read-back in write-back mode.
      send_request(1'b0, 16'h0000, 4'd1, 64'h0);
      send_request(1'b1, 16'h0000, MAX_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(1'b0, 16'h0000, MAX_SIZE, 64'h0);
      send_request(1'b1, 16'h001D, 4'd8, 64'h0123_4567_89AB_CDEF);   // crosses a line
      send_request(1'b0, 16'h001C, 4'd8, 64'h0);
      send_request(1'b1, 16'hFFFC, 4'd8, 64'hA5A5_5A5A_F00D_BEEF);   // wraps to line 0
      send_request(1'b0, 16'hFFFE, 4'd4, 64'h0);
      send_request(1'b0, 16'h0000, 4'd0, 64'h0);                     // size 0 acts as 1
      send_request(1'b1, 16'h0100, 4'd15, 64'hDEAD_BEEF_CAFE_F00D);  // size 15 acts as 8
      send_request(1'b0, 16'h0100, 4'd9, 64'h0);
      // Five tags in set 0: the fifth evicts a dirty line.
      for (int t = 1; t < 6; t++)
         send_request(1'b1, {5'(t), 11'h004}, 4'd2, 64'($urandom));
      for (int t = 0; t < 6; t++)
         send_request(1'b0, {5'(t), 11'h000}, 4'd8, 64'h0);
      drain();
   endtask

   task automatic test_write_through;
      // Dirty lines from write-back mode are dropped on eviction here.
      set_write_back(1'b0);
      for (int t = 0; t < 8; t++)
         send_request(t[0], {5'(t + 8), 11'h03E}, 4'd4, {$urandom, $urandom});
      for (int t = 0; t < 8; t++)
         send_request(1'b0, {5'(t), 11'h000}, 4'd8, 64'h0);
      set_write_back(1'b1);
   endtask

   task automatic test_backpressure;
      idle_pct  = 0;
      stall_pct = 0;
      hold_cycles = 400;
      for (int i = 0; i < 12; i++) random_request();
      drain();
   endtask

   task automatic test_random(input int count, input int idle, input int stall,
                              input bit mode);
      set_write_back(mode);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         random_request();
         // Runs of requests with no idling at all.
         if (i % 100 == 50) idle_pct = 0;
         if (i % 100 == 80) idle_pct = idle;
      end
      drain();
   endtask

   // Response side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Response monitor: every accepted response is checked against the oldest
   // prediction.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
         response_count++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[63:0], 64'h0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
            if (got.first_hit !== want.first_hit)
               report_mismatch("first_hit", 64'(got.first_hit), 64'(want.first_hit));
            if (got.crossed_line !== want.crossed_line)
               report_mismatch("crossed_line", 64'(got.crossed_line), 64'(want.crossed_line));
            if (got.second_hit !== want.second_hit)
               report_mismatch("second_hit", 64'(got.second_hit), 64'(want.second_hit));
            if (got.writebacks !== want.writebacks)
               report_mismatch("writebacks", 64'(got.writebacks), 64'(want.writebacks));
            hit_count       += want.first_hit + want.second_hit;
            cross_count     += want.crossed_line;
            writeback_count += want.writebacks;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      hold_cycles = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      error_count = 0;
      request_count = 0;
      response_count = 0;
      hit_count = 0;
      cross_count = 0;
      writeback_count = 0;
      shadow_write_back = 1'b1;
      for (int i = 0; i < NUM_SETS * NUM_WAYS; i++) begin
         shadow_tag[i]   = '0;
         shadow_valid[i] = 1'b0;
         shadow_dirty[i] = 1'b0;
      end
      for (int i = 0; i < NUM_SETS; i++) shadow_plru[i] = '0;
      for (int i = 0; i < NUM_SETS * NUM_WAYS * LINE_BYTES; i++) shadow_line[i] = '0;
      for (int i = 0; i < 65536; i++) shadow_mem[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_write_through();
      test_backpressure();
      test_random(450, 0, 0, 1'b1);
      test_random(450, 50, 0, 1'b0);
      test_random(450, 0, 50, 1'b1);
      test_random(400, 11, 11, 1'b0);
      test_random(30, 11, 11, 1'b1);

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d requests in both write policies: %0d line hits, %0d crossings,",
               request_count, hit_count, cross_count);
      $display("%0d dirty writebacks, %0d responses checked, %0d mismatches",
               writeback_count, response_count, error_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
